// File: hw/rtl/rdcw_pkg.sv
// Shared types, codes and helpers for the radio duty-cycle wakeup controller.
package rdcw_pkg;

  // Width of the tick time base; all time sums wrap at this width
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned CNT_BITS  = 8;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;

  typedef logic [TIME_BITS-1:0] tstamp_t;
  typedef logic [CNT_BITS-1:0]  count_t;

  // Operating modes; the unused code behaves as stopped with the radio off
  typedef enum logic [1:0] {
    MODE_DUTY     = 2'd0,
    MODE_STOP_OFF = 2'd1,
    MODE_STOP_ON  = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_e;

  // Phase codes as seen on the result channel
  typedef enum logic [1:0] {
    PH_SLEEP  = 2'd0,
    PH_WINDOW = 2'd1,
    PH_LISTEN = 2'd2,
    PH_SPARE  = 2'd3
  } phase_e;

  // Register indexes (byte address divided by four)
  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_CYCLE       = 3'd1,
    REG_WINDOW      = 3'd2,
    REG_LISTEN      = 3'd3,
    REG_CHECK       = 3'd4,
    REG_MAX_SILENCE = 3'd5,
    REG_MAX_IDLE    = 3'd6,
    REG_FAST_SLEEP  = 3'd7
  } reg_idx_e;

  // Register reset values
  localparam tstamp_t RST_CYCLE       = TIME_BITS'(4096);
  localparam tstamp_t RST_WINDOW      = TIME_BITS'(455);
  localparam tstamp_t RST_LISTEN      = TIME_BITS'(409);
  localparam tstamp_t RST_CHECK       = TIME_BITS'(20);
  localparam count_t  RST_MAX_SILENCE = CNT_BITS'(5);
  localparam count_t  RST_MAX_IDLE    = CNT_BITS'(10);
  localparam count_t  CNT_MAX         = '1;

  // One sampled tick
  typedef struct packed {
    logic chan_idle;
    logic rx_active;
    logic rx_pending;
    logic tx_busy;
    logic burst_rx;
  } in_t;

  // One result per tick
  typedef struct packed {
    logic       radio_enable;
    logic [1:0] phase;
    logic       activity_seen;
  } out_t;

  // Wrapping time compare: a lies before b
  function automatic logic is_before(tstamp_t a, tstamp_t b);
    tstamp_t d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

endpackage

// File: hw/rtl/radio_duty_cycle_wakeup.sv
// Radio duty-cycle wakeup controller: tick-by-tick channel sampling and listen control.
//
//  Channel   Handshake                 Payload                       Direction
//  in        in_valid_i / in_stall_o   in_data_i  (rdcw_pkg::in_t)   tick in
//  out       out_valid_o / out_stall_i out_data_o (rdcw_pkg::out_t)  result out
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata         register access
//
// One tick is taken per clock; its result appears in the output register on the
// next cycle. The whole tick update is one pass of logic from the state registers.
// The input stalls only while a result sits in the output register and the
// output side stalls. Reset clears all state but the output data and loads register defaults.
module radio_duty_cycle_wakeup (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rdcw_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rdcw_pkg::out_t                       out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rdcw_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [rdcw_pkg::DATA_BITS-1:0]       pwdata,
  output logic [rdcw_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);
  import rdcw_pkg::*;

  // Configuration registers
  mode_e   mode_q;
  tstamp_t cycle_q, window_q, listen_q, check_q;
  count_t  max_sil_q, max_idle_q;
  logic    fast_q;

  // Controller state
  tstamp_t tick_q, ncs_q, ncs_d, ps_q, ps_d, nc_q, nc_d;
  phase_e  ph_q, ph_d;
  logic    rs_q, rs_d;
  count_t  sc_q, sc_d, pc_q, pc_d;
  logic    act_d;

  // Output register
  logic out_valid_q;
  out_t out_q;

  logic     in_xfer, cfg_wr;
  reg_idx_e cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = reg_idx_e'(paddr[ADDR_BITS-1:2]);

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_DUTY;
      cycle_q    <= RST_CYCLE;
      window_q   <= RST_WINDOW;
      listen_q   <= RST_LISTEN;
      check_q    <= RST_CHECK;
      max_sil_q  <= RST_MAX_SILENCE;
      max_idle_q <= RST_MAX_IDLE;
      fast_q     <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:        mode_q     <= mode_e'(pwdata[1:0]);
        REG_CYCLE:       cycle_q    <= pwdata[TIME_BITS-1:0];
        REG_WINDOW:      window_q   <= pwdata[TIME_BITS-1:0];
        REG_LISTEN:      listen_q   <= pwdata[TIME_BITS-1:0];
        REG_CHECK:       check_q    <= pwdata[TIME_BITS-1:0];
        REG_MAX_SILENCE: max_sil_q  <= pwdata[CNT_BITS-1:0];
        REG_MAX_IDLE:    max_idle_q <= pwdata[CNT_BITS-1:0];
        REG_FAST_SLEEP:  fast_q     <= pwdata[0];
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:        prdata = DATA_BITS'(mode_q);
      REG_CYCLE:       prdata = DATA_BITS'(cycle_q);
      REG_WINDOW:      prdata = DATA_BITS'(window_q);
      REG_LISTEN:      prdata = DATA_BITS'(listen_q);
      REG_CHECK:       prdata = DATA_BITS'(check_q);
      REG_MAX_SILENCE: prdata = DATA_BITS'(max_sil_q);
      REG_MAX_IDLE:    prdata = DATA_BITS'(max_idle_q);
      REG_FAST_SLEEP:  prdata = DATA_BITS'(fast_q);
    endcase
  end

  // Tick update: stopped modes, window sampling, cycle start and listen checks
  always_comb begin
    logic run_window, do_listen, finish, off, lim_ok, quiet, rx_any;
    ncs_d      = ncs_q;
    ps_d       = ps_q;
    nc_d       = nc_q;
    ph_d       = ph_q;
    rs_d       = rs_q;
    sc_d       = sc_q;
    pc_d       = pc_q;
    act_d      = 1'b0;
    run_window = 1'b0;
    do_listen  = 1'b0;
    finish     = 1'b0;
    off        = 1'b0;
    lim_ok     = 1'b0;
    rx_any     = in_data_i.rx_active || in_data_i.rx_pending;
    quiet      = !in_data_i.tx_busy && !in_data_i.burst_rx;

    if (mode_q != MODE_DUTY) begin
      // Stopped: force the radio and hold the cycle one period away
      rs_d  = (mode_q == MODE_STOP_ON);
      ph_d  = PH_SLEEP;
      sc_d  = '0;
      pc_d  = '0;
      ncs_d = tick_q + cycle_q;
    end else begin
      // Select the work for this tick
      unique case (ph_q)
        PH_WINDOW: run_window = 1'b1;
        PH_LISTEN: do_listen  = !is_before(tick_q, nc_q);
        default: begin
          if (!is_before(tick_q, ncs_q)) begin
            if (!quiet) begin
              ncs_d = ncs_q + cycle_q + window_q;
              ph_d  = PH_SLEEP;
            end else begin
              rs_d       = 1'b1;
              ps_d       = tick_q;
              ph_d       = PH_WINDOW;
              run_window = 1'b1;
            end
          end
        end
      endcase

      // Sample the channel inside the active window, else close the cycle
      if (run_window) begin
        if (is_before(tick_q, ps_d + window_q)) begin
          if (!in_data_i.chan_idle) begin
            act_d     = 1'b1;
            ph_d      = PH_LISTEN;
            ps_d      = tick_q;
            sc_d      = '0;
            pc_d      = '0;
            do_listen = 1'b1;
          end
        end else begin
          if (quiet) rs_d = 1'b0;
          ncs_d = ncs_q + cycle_q + window_q;
          ph_d  = PH_SLEEP;
        end
      end

      // Listen check: count silent and total periods, decide to stop
      if (do_listen) begin
        lim_ok = is_before(tick_q, ps_d + listen_q);
        if (in_data_i.tx_busy || !rs_d || !lim_ok) begin
          finish = 1'b1;
        end else begin
          if (in_data_i.rx_active || !in_data_i.chan_idle) begin
            sc_d = '0;
          end else if (sc_d != CNT_MAX) begin
            sc_d = sc_d + 1'b1;
          end
          if (pc_d != CNT_MAX) pc_d = pc_d + 1'b1;
          priority if (sc_d > max_sil_q) begin
            off    = 1'b1;
            finish = 1'b1;
          end else if (fast_q && pc_d > max_idle_q && !rx_any) begin
            off    = 1'b1;
            finish = 1'b1;
          end else if (in_data_i.rx_pending) begin
            finish = 1'b1;
          end else begin
            nc_d = tick_q + check_q;
          end
        end
        if (off && quiet) rs_d = 1'b0;
        if (finish) begin
          if (rs_d && (!rx_any || !lim_ok) && quiet) rs_d = 1'b0;
          ncs_d = ncs_q + cycle_q + window_q;
          ph_d  = PH_SLEEP;
        end
      end
    end
  end

  // Advance state on each tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      ncs_q  <= '0;
      ps_q   <= '0;
      nc_q   <= '0;
      ph_q   <= PH_SLEEP;
      rs_q   <= 1'b0;
      sc_q   <= '0;
      pc_q   <= '0;
    end else if (in_xfer) begin
      tick_q <= tick_q + 1'b1;
      ncs_q  <= ncs_d;
      ps_q   <= ps_d;
      nc_q   <= nc_d;
      ph_q   <= ph_d;
      rs_q   <= rs_d;
      sc_q   <= sc_d;
      pc_q   <= pc_d;
    end
  end

  // Hold the result until the output side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q.radio_enable  <= rs_d;
      out_q.phase         <= ph_d;
      out_q.activity_seen <= act_d;
    end
  end

  // Activity always moves the controller out of the active window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.activity_seen) |-> (out_q.phase != PH_WINDOW))
    else $error("activity reported inside the active window");

  // Stopped modes give a sleeping phase and the forced radio state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode_q != MODE_DUTY) |=>
      (out_q.phase == PH_SLEEP && out_q.radio_enable == $past(mode_q == MODE_STOP_ON)))
    else $error("stopped mode result wrong");

  // Tick time advances by one per transfer and holds otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (tick_q == tstamp_t'($past(tick_q) + 1'b1)))
    else $error("tick time did not advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(tick_q))
    else $error("tick time moved without a transfer");

  // A held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost");

endmodule
